[sv/selt_pkg.sv]
// ---------------------------------------------------------------------------
// selt_pkg: shared/exclusive lock table definitions
// Operation and status codes, field widths and parameter defaults.
// ---------------------------------------------------------------------------
`default_nettype none

package selt_pkg;

   localparam int unsigned ENTRIES_DEF    = 16;
   localparam int unsigned KEY_BITS_DEF   = 32;
   localparam int unsigned COUNT_BITS_DEF = 8;

   localparam int unsigned ID_W     = 32;
   localparam int unsigned OP_W     = 2;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned LOCK_W   = 9;
   localparam int unsigned RSP_DATA_W = 16;

   typedef enum logic [OP_W-1:0] {
      OP_SHARED    = 2'd0,
      OP_EXCLUSIVE = 2'd1,
      OP_RELEASE   = 2'd2,
      OP_CLEAR     = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_GRANTED   = 3'd0,
      ST_CONFLICT  = 3'd1,
      ST_FULL      = 3'd2,
      ST_SATURATED = 3'd3,
      ST_RELEASED  = 3'd4
   } status_type;

   localparam logic [LOCK_W-1:0] LOCK_EXCL = '1;
   localparam logic [LOCK_W-1:0] LOCK_FREE = '0;

endpackage

`default_nettype wire

[sv/shared_exclusive_lock_table_core.sv]
// ---------------------------------------------------------------------------
// shared_exclusive_lock_table_core: fully associative shared/exclusive lock table
// Looks up a block key across all entries in parallel and grants, refuses,
// releases or clears locks, giving one response per request.
// ---------------------------------------------------------------------------
// The request is captured in the request stage and its response in the response
// stage. Throughput: 1 request per cycle unless the response stage stalls;
// lookup and entry update are done by the parallel key compare between the
// request and response registers.
// Reset: synchronous, clears all entry valid bits and both stage valids;
// keys and counts are left as they are and only read behind a valid bit.
`default_nettype none

module shared_exclusive_lock_table_core #(
   parameter int unsigned ENTRIES    = selt_pkg::ENTRIES_DEF,
   parameter int unsigned KEY_BITS   = selt_pkg::KEY_BITS_DEF,
   parameter int unsigned COUNT_BITS = selt_pkg::COUNT_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [selt_pkg::ID_W-1:0]       req_tdata,  // block_id
   input  wire logic [selt_pkg::OP_W-1:0]       req_tuser,  // operation
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [selt_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // lock_value, zero fill
   output logic [selt_pkg::STATUS_W-1:0]        rsp_tuser   // status
);
   import selt_pkg::*;

   localparam int unsigned SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // request stage
   logic                  req_vld_ff;
   logic [OP_W-1:0]       req_op_ff;
   logic [KEY_BITS-1:0]   req_key_ff;
   logic                  advance;

   // table
   logic [ENTRIES-1:0]    valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_ff  [ENTRIES];
   logic                  excl_ff [ENTRIES];
   logic [COUNT_BITS-1:0] cnt_ff  [ENTRIES];

   // response stage
   logic                  rsp_vld_ff;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [LOCK_W-1:0]     rsp_lock_ff, rsp_lock_in;

   // lookup
   logic [ENTRIES-1:0]    hit;
   logic                  found;
   logic                  hit_excl;
   logic [COUNT_BITS-1:0] hit_cnt;
   logic [SLOT_W-1:0]     hit_slot;
   logic                  any_free;
   logic [SLOT_W-1:0]     free_slot;

   // update
   logic                  wr_en;
   logic                  wr_new;
   logic [SLOT_W-1:0]     wr_slot;
   logic                  wr_excl;
   logic [COUNT_BITS-1:0] wr_cnt;
   logic [COUNT_BITS-1:0] cnt_inc, cnt_dec;

   function automatic logic [LOCK_W-1:0] cnt_to_lock(input logic [COUNT_BITS-1:0] c);
      logic [COUNT_BITS+LOCK_W-1:0] ext;
      ext = (COUNT_BITS+LOCK_W)'(c);
      return ext[LOCK_W-1:0];
   endfunction

   assign advance    = req_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !req_vld_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (req_tready) begin
         req_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_op_ff  <= req_tuser;
         req_key_ff <= KEY_BITS'((ID_W+KEY_BITS)'(req_tdata));
      end
   end

   always_comb begin
      found    = 1'b0;
      hit_excl = 1'b0;
      hit_cnt  = '0;
      hit_slot = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit[i] = valid_ff[i] && (key_ff[i] == req_key_ff);
         if (hit[i]) begin
            found    = 1'b1;
            hit_excl = hit_excl | excl_ff[i];
            hit_cnt  = hit_cnt | cnt_ff[i];
            hit_slot = hit_slot | SLOT_W'(i);
         end
      end
   end

   always_comb begin
      any_free  = 1'b0;
      free_slot = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            any_free  = 1'b1;
            free_slot = SLOT_W'(i);
         end
      end
   end

   assign cnt_inc = hit_cnt + COUNT_BITS'(1);
   assign cnt_dec = hit_cnt - COUNT_BITS'(1);

   always_comb begin
      wr_en         = 1'b0;
      wr_new        = !found;
      wr_slot       = found ? hit_slot : free_slot;
      wr_excl       = 1'b0;
      wr_cnt        = '0;
      valid_in      = valid_ff;
      rsp_status_in = ST_RELEASED;
      rsp_lock_in   = LOCK_FREE;
      case (op_type'(req_op_ff))
         OP_SHARED: begin
            if (found && hit_excl) begin
               rsp_status_in = ST_CONFLICT;
               rsp_lock_in   = LOCK_EXCL;
            end else if (found && hit_cnt == COUNT_MAX) begin
               rsp_status_in = ST_SATURATED;
               rsp_lock_in   = cnt_to_lock(hit_cnt);
            end else if (!found && !any_free) begin
               rsp_status_in = ST_FULL;
            end else begin
               wr_en         = 1'b1;
               wr_cnt        = found ? cnt_inc : COUNT_BITS'(1);
               rsp_status_in = ST_GRANTED;
               rsp_lock_in   = cnt_to_lock(wr_cnt);
            end
         end
         OP_EXCLUSIVE: begin
            if (found && !hit_excl && hit_cnt > COUNT_BITS'(1)) begin
               rsp_status_in = ST_CONFLICT;
               rsp_lock_in   = cnt_to_lock(hit_cnt);
            end else if (!found && !any_free) begin
               rsp_status_in = ST_FULL;
            end else begin
               wr_en         = 1'b1;
               wr_excl       = 1'b1;
               rsp_status_in = ST_GRANTED;
               rsp_lock_in   = LOCK_EXCL;
            end
         end
         OP_RELEASE: begin
            if (found && !hit_excl && hit_cnt > COUNT_BITS'(1)) begin
               wr_en       = 1'b1;
               wr_cnt      = cnt_dec;
               rsp_lock_in = cnt_to_lock(cnt_dec);
            end else begin
               valid_in = valid_ff & ~hit;
            end
         end
         OP_CLEAR: begin
            valid_in = '0;
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
      if (wr_en) begin
         valid_in[wr_slot] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && wr_en) begin
         excl_ff[wr_slot] <= wr_excl;
         cnt_ff[wr_slot]  <= wr_cnt;
         if (wr_new) begin
            key_ff[wr_slot] <= req_key_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= rsp_status_in;
         rsp_lock_ff   <= rsp_lock_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_lock_ff);

endmodule

`default_nettype wire
